>>> sv/sme_pkg.sv
// ----------------------------------------------------------------------------
// sme_pkg: shared types and constants of the stack machine executor
// opcodes, fault codes, cell control and the result record
// ----------------------------------------------------------------------------
package sme_pkg;

  localparam int unsigned WORD_W     = 32;
  localparam int unsigned KIND_W     = 5;
  localparam int unsigned ADDR_OUT_W = 10;

  localparam logic [WORD_W-1:0] ALL_ONES = '1;
  localparam logic [WORD_W-1:0] WORD_ONE = WORD_W'(1);

  typedef enum logic [KIND_W-1:0] {
    OP_STOP     = 5'd0,
    OP_NEXT     = 5'd1,
    OP_DUP      = 5'd2,
    OP_OVER     = 5'd3,
    OP_PICK     = 5'd4,
    OP_SWAP     = 5'd5,
    OP_ROT      = 5'd6,
    OP_DROP     = 5'd7,
    OP_SKIPIF   = 5'd8,
    OP_FWD      = 5'd9,
    OP_REW      = 5'd10,
    OP_ZERO     = 5'd11,
    OP_ONE      = 5'd12,
    OP_NEGONE   = 5'd13,
    OP_LIT      = 5'd14,
    OP_ADD      = 5'd15,
    OP_MUL      = 5'd16,
    OP_AND      = 5'd17,
    OP_OR       = 5'd18,
    OP_XOR      = 5'd19,
    OP_RSHIFT   = 5'd20,
    OP_LSHIFT   = 5'd21,
    OP_WRITEHEX = 5'd22
  } op_e;

  typedef enum logic [1:0] {
    FAULT_NONE  = 2'd0,
    FAULT_UNDER = 2'd1,
    FAULT_OVER  = 2'd2,
    FAULT_BAD   = 2'd3
  } fault_e;

  // what a stack cell takes as its word in the next cycle
  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_FROM_UP,
    CELL_FROM_DOWN,
    CELL_LOAD
  } cell_mode_e;

  // what a stack cell takes as its probe in the next cycle
  typedef enum logic [1:0] {
    PROBE_HOLD,
    PROBE_LOAD,
    PROBE_SHIFT
  } probe_mode_e;

  typedef struct packed {
    cell_mode_e  mode;
    probe_mode_e probe;
  } cell_ctl_t;

  typedef struct packed {
    logic [ADDR_OUT_W-1:0] next_address;
    logic                  emit_valid;
    logic [WORD_W-1:0]     emit_value;
    logic                  halted;
    fault_e                fault;
  } result_t;

endpackage

>>> sv/sme_cell.sv
// ----------------------------------------------------------------------------
// sme_cell: one entry of the shifting data stack
// holds a stack word and a probe word used by the pick walk
// ----------------------------------------------------------------------------
module sme_cell (
  input  logic                       clk_i,
  input  sme_pkg::cell_ctl_t         ctl_i,
  input  logic [sme_pkg::WORD_W-1:0] load_word_i,
  input  logic [sme_pkg::WORD_W-1:0] up_word_i,
  input  logic [sme_pkg::WORD_W-1:0] down_word_i,
  input  logic [sme_pkg::WORD_W-1:0] down_probe_i,
  output logic [sme_pkg::WORD_W-1:0] word_o,
  output logic [sme_pkg::WORD_W-1:0] probe_o
);
  import sme_pkg::*;

  logic [WORD_W-1:0] word_q, word_d;
  logic [WORD_W-1:0] probe_q, probe_d;

  always_comb begin
    case (ctl_i.mode)
      CELL_FROM_UP:   word_d = up_word_i;
      CELL_FROM_DOWN: word_d = down_word_i;
      CELL_LOAD:      word_d = load_word_i;
      default:        word_d = word_q;
    endcase
  end

  // probe load copies the word below, so the top probe starts at depth one
  always_comb begin
    case (ctl_i.probe)
      PROBE_LOAD:  probe_d = down_word_i;
      PROBE_SHIFT: probe_d = down_probe_i;
      default:     probe_d = probe_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    word_q  <= word_d;
    probe_q <= probe_d;
  end

  assign word_o  = word_q;
  assign probe_o = probe_q;

endmodule

>>> sv/sme_addr.sv
// ----------------------------------------------------------------------------
// sme_addr: next fetch address candidates
// computes ip+1, ip+2, forward and backward jumps modulo the program size
// ----------------------------------------------------------------------------
module sme_addr #(
  parameter int unsigned PROGRAM_WORDS = 1024
) (
  input  logic [$clog2(PROGRAM_WORDS)-1:0] ip_i,
  input  logic [sme_pkg::WORD_W-1:0]       value_i,
  output logic [$clog2(PROGRAM_WORDS)-1:0] inc1_o,
  output logic [$clog2(PROGRAM_WORDS)-1:0] inc2_o,
  output logic [$clog2(PROGRAM_WORDS)-1:0] fwd_o,
  output logic [$clog2(PROGRAM_WORDS)-1:0] rew_o
);
  import sme_pkg::*;

  localparam int unsigned AW    = $clog2(PROGRAM_WORDS);
  localparam int unsigned SW    = AW + 2;
  localparam int unsigned TWO_P = 2 * PROGRAM_WORDS;
  localparam logic [AW:0]   PW  = PROGRAM_WORDS[AW:0];
  localparam logic [SW-1:0] PW2 = TWO_P[SW-1:0];

  // (b * 2^shift) mod modulus by doubling, evaluated at elaboration
  function automatic int unsigned byte_residue(input int unsigned b,
                                               input int unsigned shift,
                                               input int unsigned modulus);
    int unsigned r;
    r = 0;
    for (int i = 7; i >= 0; i--) begin
      r = 2 * r + ((b >> i) & 1);
      if (r >= modulus) r = r - modulus;
    end
    for (int i = 0; i < int'(shift); i++) begin
      r = 2 * r;
      if (r >= modulus) r = r - modulus;
    end
    return r;
  endfunction

  // one conditional subtract, valid for x below twice the program size
  function automatic logic [AW-1:0] fold(input logic [AW:0] x);
    logic [AW:0] y;
    y = (x >= PW) ? x - PW : x;
    return y[AW-1:0];
  endfunction

  logic [AW-1:0] residue [4][256];
  logic [SW-1:0] sum;
  logic [SW-1:0] sum_half;
  logic [AW-1:0] m;
  logic [AW-1:0] ip1;

  // per-byte residue tables of the popped value
  for (genvar k = 0; k < 4; k++) begin : g_byte
    for (genvar b = 0; b < 256; b++) begin : g_val
      localparam int unsigned R = byte_residue(b, 8 * k, PROGRAM_WORDS);
      assign residue[k][b] = R[AW-1:0];
    end
  end

  assign sum = SW'(residue[0][value_i[7:0]])   + SW'(residue[1][value_i[15:8]]) +
               SW'(residue[2][value_i[23:16]]) + SW'(residue[3][value_i[31:24]]);
  assign sum_half = (sum >= PW2) ? sum - PW2 : sum;
  assign m        = fold(sum_half[AW:0]);

  assign ip1    = fold({1'b0, ip_i} + (AW+1)'(1));
  assign inc1_o = ip1;
  assign inc2_o = fold({1'b0, ip1} + (AW+1)'(1));
  assign fwd_o  = fold({1'b0, ip1} + {1'b0, m});
  assign rew_o  = fold({1'b0, ip1} + (PW - {1'b0, m}));

endmodule

>>> sv/stack_machine_executor.sv
// ----------------------------------------------------------------------------
// stack_machine_executor: forth-style 32-bit stack machine, one opcode per item
// executes a fetched opcode and the word after it on a shifting data stack
// ----------------------------------------------------------------------------
// Each item is one opcode (kind_i) plus the program word after it
// (following_word_i); each item returns one result: the next fetch address,
// a writehex value, a halt mark and a fault code. The data stack is a chain
// of STACK_ENTRIES cells with the top in cell 0; push and pop shift every
// cell by one place together, so every opcode but pick is done when it is
// accepted and items can follow back to back. Pick with index n moves the
// probe words of the chain up one cell per cycle until the picked entry
// reaches the top, and no item is accepted during that walk. The result of
// an accepted item is registered; an output register plus one skid entry
// let a new item in while a result is stalled. A fault leaves the stack
// and the address untouched. Stack contents need no clearing after reset:
// only entries below the current depth are read.
// ----------------------------------------------------------------------------
module stack_machine_executor #(
  parameter int unsigned STACK_ENTRIES = 64,
  parameter int unsigned PROGRAM_WORDS = 1024
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // item input
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic [sme_pkg::KIND_W-1:0]     kind_i,
  input  logic [sme_pkg::WORD_W-1:0]     following_word_i,
  // result output
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [sme_pkg::ADDR_OUT_W-1:0] next_address_o,
  output logic                           emit_valid_o,
  output logic [sme_pkg::WORD_W-1:0]     emit_value_o,
  output logic                           halted_o,
  output logic [1:0]                     fault_o
);
  import sme_pkg::*;

  localparam int unsigned DW  = $clog2(STACK_ENTRIES + 1);
  localparam int unsigned CW  = $clog2(STACK_ENTRIES);
  localparam int unsigned AW  = $clog2(PROGRAM_WORDS);
  localparam int unsigned AWX = (AW > ADDR_OUT_W) ? AW : ADDR_OUT_W;
  localparam logic [DW-1:0] FULL = STACK_ENTRIES[DW-1:0];

  // control state
  logic [DW-1:0] depth_q, depth_d;
  logic [AW-1:0] ip_q, ip_d;
  logic          busy_q, busy_d;      // pick walk in progress
  logic [CW-1:0] cnt_q, cnt_d;        // probe shifts still to go
  logic          out_valid_q, out_valid_d;
  logic          skid_valid_q, skid_valid_d;

  // result payload
  result_t out_q, out_d;
  result_t skid_q, skid_d;
  result_t res;

  // stack chain
  logic [WORD_W-1:0] word  [STACK_ENTRIES];
  logic [WORD_W-1:0] probe [STACK_ENTRIES];
  cell_mode_e        top_mode [3];
  logic [WORD_W-1:0] top_load [3];
  cell_mode_e        rest_mode;
  probe_mode_e       probe_mode;

  logic [WORD_W-1:0] top0, top1, top2;

  // decode
  op_e           op;
  logic [1:0]    need;
  logic          push;
  logic          valid_op;
  fault_e        fault;
  logic          accept;
  logic          commit;
  logic [WORD_W-1:0] depth_m1;
  logic [WORD_W-1:0] alu_r;
  logic [WORD_W-1:0] prod;

  // execute
  logic [AW-1:0]  next_addr;
  logic [DW-1:0]  depth_n;
  logic           emit;
  logic           halt;
  logic           start_pick;
  logic [AWX-1:0] next_ext;

  // address candidates
  logic [AW-1:0] inc1, inc2, fwd, rew;

  assign top0 = word[0];
  assign top1 = word[1];
  assign top2 = word[2];

  assign in_stall_o = busy_q | skid_valid_q;
  assign accept     = in_valid_i & ~in_stall_o;

  sme_addr #(
    .PROGRAM_WORDS(PROGRAM_WORDS)
  ) u_addr (
    .ip_i    (ip_q),
    .value_i (top0),
    .inc1_o  (inc1),
    .inc2_o  (inc2),
    .fwd_o   (fwd),
    .rew_o   (rew)
  );

  // items consumed and pushes per opcode
  always_comb begin
    op       = op_e'(kind_i);
    need     = 2'd0;
    push     = 1'b0;
    valid_op = 1'b1;
    case (op)
      OP_STOP, OP_NEXT: ;
      OP_DUP:  begin need = 2'd1; push = 1'b1; end
      OP_OVER: begin need = 2'd2; push = 1'b1; end
      OP_PICK: need = 2'd1;
      OP_SWAP: need = 2'd2;
      OP_ROT:  need = 2'd3;
      OP_ZERO, OP_ONE, OP_NEGONE, OP_LIT: push = 1'b1;
      OP_DROP, OP_SKIPIF, OP_FWD, OP_REW, OP_WRITEHEX: need = 2'd1;
      OP_ADD, OP_MUL, OP_AND, OP_OR, OP_XOR, OP_RSHIFT, OP_LSHIFT: need = 2'd2;
      default: valid_op = 1'b0;
    endcase
  end

  // fault priority: bad opcode, too few items, pick out of range, full stack
  assign depth_m1 = WORD_W'(depth_q) - WORD_ONE;

  always_comb begin
    if (!valid_op) begin
      fault = FAULT_BAD;
    end else if (depth_q < DW'(need)) begin
      fault = FAULT_UNDER;
    end else if (op == OP_PICK && top0 >= depth_m1) begin
      fault = FAULT_UNDER;
    end else if (push && depth_q == FULL) begin
      fault = FAULT_OVER;
    end else begin
      fault = FAULT_NONE;
    end
  end

  assign commit = accept & (fault == FAULT_NONE);

  // binary operators: second item op top item
  assign prod = top1 * top0;

  always_comb begin
    case (op)
      OP_ADD:    alu_r = top1 + top0;
      OP_MUL:    alu_r = prod;
      OP_AND:    alu_r = top1 & top0;
      OP_OR:     alu_r = top1 | top0;
      OP_XOR:    alu_r = top1 ^ top0;
      OP_RSHIFT: alu_r = (top0 >= WORD_W) ? '0 : top1 >> top0[4:0];
      OP_LSHIFT: alu_r = (top0 >= WORD_W) ? '0 : top1 << top0[4:0];
      default:   alu_r = '0;
    endcase
  end

  // execute: stack moves, next address and result fields
  always_comb begin
    next_addr   = inc1;
    depth_n     = depth_q;
    emit        = 1'b0;
    halt        = 1'b0;
    start_pick  = 1'b0;
    rest_mode   = CELL_HOLD;
    probe_mode  = PROBE_HOLD;
    top_mode    = '{CELL_HOLD, CELL_HOLD, CELL_HOLD};
    top_load    = '{'0, '0, '0};
    busy_d      = busy_q;
    cnt_d       = cnt_q;

    case (op)
      OP_STOP: begin
        halt      = 1'b1;
        next_addr = '0;
      end
      OP_DUP, OP_OVER, OP_ZERO, OP_ONE, OP_NEGONE, OP_LIT: begin
        // push: everything moves one cell down, new top loads into cell 0
        rest_mode   = CELL_FROM_UP;
        top_mode    = '{CELL_LOAD, CELL_FROM_UP, CELL_FROM_UP};
        depth_n     = depth_q + DW'(1);
        case (op)
          OP_DUP:    top_load[0] = top0;
          OP_OVER:   top_load[0] = top1;
          OP_ONE:    top_load[0] = WORD_ONE;
          OP_NEGONE: top_load[0] = ALL_ONES;
          OP_LIT:    top_load[0] = following_word_i;
          default:   top_load[0] = '0;
        endcase
        if (op == OP_LIT) next_addr = inc2;
      end
      OP_PICK: begin
        probe_mode = PROBE_LOAD;
        start_pick = 1'b1;
      end
      OP_SWAP: begin
        top_mode = '{CELL_LOAD, CELL_LOAD, CELL_HOLD};
        top_load = '{top1, top0, '0};
      end
      OP_ROT: begin
        // ( a b c -- b c a ) with c on top
        top_mode = '{CELL_LOAD, CELL_LOAD, CELL_LOAD};
        top_load = '{top2, top0, top1};
      end
      OP_DROP, OP_SKIPIF, OP_FWD, OP_REW, OP_WRITEHEX: begin
        rest_mode = CELL_FROM_DOWN;
        top_mode  = '{CELL_FROM_DOWN, CELL_FROM_DOWN, CELL_FROM_DOWN};
        depth_n   = depth_q - DW'(1);
        case (op)
          OP_SKIPIF:   next_addr = (top0 != '0) ? inc2 : inc1;
          OP_FWD:      next_addr = fwd;
          OP_REW:      next_addr = rew;
          OP_WRITEHEX: emit = 1'b1;
          default:     next_addr = inc1;
        endcase
      end
      OP_ADD, OP_MUL, OP_AND, OP_OR, OP_XOR, OP_RSHIFT, OP_LSHIFT: begin
        // two items in, result replaces them as the new top
        rest_mode   = CELL_FROM_DOWN;
        top_mode    = '{CELL_LOAD, CELL_FROM_DOWN, CELL_FROM_DOWN};
        top_load[0] = alu_r;
        depth_n     = depth_q - DW'(1);
      end
      default: ;
    endcase

    // faulted or idle: nothing moves, apart from a pick walk handled below
    if (!commit) begin
      rest_mode  = CELL_HOLD;
      probe_mode = PROBE_HOLD;
      top_mode   = '{CELL_HOLD, CELL_HOLD, CELL_HOLD};
      start_pick = 1'b0;
    end

    if (start_pick) begin
      busy_d = 1'b1;
      cnt_d  = top0[CW-1:0];
    end

    // pick walk: shift probes up until the picked entry is in cell 0
    if (busy_q) begin
      if (cnt_q == '0) begin
        top_mode[0] = CELL_LOAD;
        top_load[0] = probe[0];
        busy_d      = 1'b0;
      end else begin
        probe_mode = PROBE_SHIFT;
        cnt_d      = cnt_q - CW'(1);
      end
    end

    if (fault != FAULT_NONE) begin
      next_addr = ip_q;
      emit      = 1'b0;
      halt      = 1'b0;
    end
  end

  assign ip_d    = commit ? next_addr : ip_q;
  assign depth_d = commit ? depth_n : depth_q;

  assign next_ext         = AWX'(next_addr);
  assign res.next_address = next_ext[ADDR_OUT_W-1:0];
  assign res.emit_valid   = emit;
  assign res.emit_value   = emit ? top0 : '0;
  assign res.halted       = halt;
  assign res.fault        = fault;

  // the chain of stack cells, top at index 0
  for (genvar i = 0; i < STACK_ENTRIES; i++) begin : g_cell
    logic [WORD_W-1:0] up_w, down_w, down_p, load_w;
    cell_ctl_t         ctl;

    if (i == 0) begin : g_first
      assign up_w = '0;
    end else begin : g_mid
      assign up_w = word[i-1];
    end

    if (i == STACK_ENTRIES - 1) begin : g_last
      assign down_w = '0;
      assign down_p = '0;
    end else begin : g_lower
      assign down_w = word[i+1];
      assign down_p = probe[i+1];
    end

    if (i < 3) begin : g_top
      assign ctl.mode = top_mode[i];
      assign load_w   = top_load[i];
    end else begin : g_rest
      assign ctl.mode = rest_mode;
      assign load_w   = '0;
    end
    assign ctl.probe = probe_mode;

    sme_cell u_cell (
      .clk_i        (clk_i),
      .ctl_i        (ctl),
      .load_word_i  (load_w),
      .up_word_i    (up_w),
      .down_word_i  (down_w),
      .down_probe_i (down_p),
      .word_o       (word[i]),
      .probe_o      (probe[i])
    );
  end

  // output register with one skid entry
  always_comb begin
    out_valid_d  = out_valid_q;
    out_d        = out_q;
    skid_valid_d = skid_valid_q;
    skid_d       = skid_q;
    if (!out_valid_q || !out_stall_i) begin
      if (skid_valid_q) begin
        out_valid_d  = 1'b1;
        out_d        = skid_q;
        skid_valid_d = 1'b0;
      end else begin
        out_valid_d = accept;
        out_d       = res;
      end
    end else if (accept) begin
      skid_valid_d = 1'b1;
      skid_d       = res;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      depth_q      <= '0;
      ip_q         <= '0;
      busy_q       <= 1'b0;
      cnt_q        <= '0;
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      depth_q      <= depth_d;
      ip_q         <= ip_d;
      busy_q       <= busy_d;
      cnt_q        <= cnt_d;
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

  assign out_valid_o    = out_valid_q;
  assign next_address_o = out_q.next_address;
  assign emit_valid_o   = out_q.emit_valid;
  assign emit_value_o   = out_q.emit_value;
  assign halted_o       = out_q.halted;
  assign fault_o        = out_q.fault;

endmodule

>>> sv/sme_checker.sv
// ----------------------------------------------------------------------------
// sme_checker: port-level checks of the stack machine executor
// watches the result channel and the input stall over time
// ----------------------------------------------------------------------------
module sme_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           in_valid_i,
  input logic                           in_stall_o,
  input logic                           out_valid_o,
  input logic                           out_stall_i,
  input logic [sme_pkg::ADDR_OUT_W-1:0] next_address_o,
  input logic                           emit_valid_o,
  input logic [sme_pkg::WORD_W-1:0]     emit_value_o,
  input logic                           halted_o,
  input logic [1:0]                     fault_o
);
  import sme_pkg::*;

  // stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=>
      (out_valid_o && $stable(next_address_o) && $stable(emit_valid_o) &&
       $stable(emit_value_o) && $stable(halted_o) && $stable(fault_o)))
    else $error("stalled result changed");

  // a faulted item emits nothing and does not halt
  a_fault_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && fault_o != FAULT_NONE) |-> (!emit_valid_o && !halted_o))
    else $error("faulted item emitted or halted");

  // stop restarts at address zero without a fault
  a_halt_addr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && halted_o) |-> (next_address_o == '0 && fault_o == FAULT_NONE))
    else $error("halt with nonzero address or fault");

  // emitted value is zero unless writehex fired
  a_emit_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !emit_valid_o) |-> (emit_value_o == '0))
    else $error("emit value without emit valid");

  // an item taken while the result is stalled fills the skid entry
  a_skid_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o && out_valid_o && out_stall_i) |=> in_stall_o)
    else $error("item accepted with no room behind a stalled result");

endmodule

bind stack_machine_executor sme_checker u_sme_checker (.*);
